// ===== hdl/lcm_pkg.sv =====
// Shared widths, state encoding and controller/datapath handshake types.
`timescale 1ns / 1ps

package lcm_pkg;

   localparam int OPERAND_WIDTH = 16;
   localparam int RESULT_WIDTH  = 32;
   localparam int COUNT_WIDTH   = (OPERAND_WIDTH > 1) ? $clog2(OPERAND_WIDTH) : 1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_SEARCH
   } lcm_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic search_step;
      logic load_out;
   } lcm_cmd_type;

   typedef struct packed {
      logic small_zero;
      logic div_last;
      logic hit;
      logic slot_free;
   } lcm_status_type;

endpackage

// ===== hdl/lcm_if.sv =====
// Valid/ready channel interfaces for operand and result beats.
`timescale 1ns / 1ps

interface lcm_req_if;
   logic                             valid;
   logic                             ready;
   logic [lcm_pkg::OPERAND_WIDTH-1:0] first_operand;
   logic [lcm_pkg::OPERAND_WIDTH-1:0] second_operand;

   modport source (output valid, output first_operand, output second_operand, input ready);
   modport sink   (input valid, input first_operand, input second_operand, output ready);
endinterface

interface lcm_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lcm_pkg::RESULT_WIDTH-1:0] multiple;

   modport source (output valid, output multiple, input ready);
   modport sink   (input valid, input multiple, output ready);
endinterface

// ===== hdl/lcm_ctrl.sv =====
// Sequencing state machine: load, remainder division, multiple search, hand-off.
`timescale 1ns / 1ps

module lcm_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  lcm_pkg::lcm_status_type status,
   output lcm_pkg::lcm_cmd_type    cmd
);
   import lcm_pkg::*;

   lcm_state_type state_ff;
   lcm_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            // a zero smaller operand needs no remainder: the search hits at once
            if (status.small_zero) begin
               state_in = ST_SEARCH;
            end else begin
               cmd.div_step = 1'b1;
               if (status.div_last) begin
                  state_in = ST_SEARCH;
               end
            end
         end
         ST_SEARCH: begin
            if (status.hit) begin
               // hold the answer until the output register can take it
               if (status.slot_free) begin
                  cmd.load_out = 1'b1;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.search_step = 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   no_step_while_idle : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !(cmd.div_step || cmd.search_step || cmd.load_out))
      else $error("datapath stepped while idle");

   search_follows_division : assert property (@(posedge clock) disable iff (reset)
      (cmd.div_step && status.div_last) |=> (state_ff == ST_SEARCH))
      else $error("search did not follow the last division step");

   result_only_on_hit : assert property (@(posedge clock) disable iff (reset)
      $rose(state_ff == ST_IDLE) |-> $past(status.hit && status.slot_free))
      else $error("returned to idle without a delivered result");

endmodule

// ===== hdl/lcm_datapath.sv =====
// Operand registers, bit-serial remainder unit, running-remainder search, result register.
`timescale 1ns / 1ps

module lcm_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0]   first_operand,
   input  logic [lcm_pkg::OPERAND_WIDTH-1:0]   second_operand,
   input  lcm_pkg::lcm_cmd_type                cmd,
   output lcm_pkg::lcm_status_type             status,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic [lcm_pkg::RESULT_WIDTH-1:0]    rsp_multiple
);
   import lcm_pkg::*;

   logic                     first_gt;
   logic [OPERAND_WIDTH-1:0] big;
   logic [OPERAND_WIDTH-1:0] small_op;

   logic [OPERAND_WIDTH-1:0] big_ff;
   logic [OPERAND_WIDTH-1:0] small_ff;
   logic [OPERAND_WIDTH-1:0] shift_ff;
   logic [OPERAND_WIDTH:0]   part_ff;
   logic [COUNT_WIDTH-1:0]   cnt_ff;
   logic [OPERAND_WIDTH-1:0] d_ff;
   logic [OPERAND_WIDTH-1:0] r_ff;
   logic [RESULT_WIDTH-1:0]  acc_ff;
   logic [RESULT_WIDTH-1:0]  out_ff;
   logic                     out_valid_ff;

   logic [OPERAND_WIDTH:0]   shifted;
   logic [OPERAND_WIDTH:0]   part_in;
   logic [OPERAND_WIDTH:0]   sum;
   logic [OPERAND_WIDTH:0]   sum_red;
   logic [OPERAND_WIDTH:0]   small_ext;

   assign first_gt  = first_operand > second_operand;
   assign big       = first_gt ? first_operand : second_operand;
   assign small_op  = first_gt ? second_operand : first_operand;
   assign small_ext = {1'b0, small_ff};

   // restoring remainder step: one dividend bit per beat
   assign shifted = {part_ff[OPERAND_WIDTH-1:0], shift_ff[OPERAND_WIDTH-1]};
   assign part_in = (shifted >= small_ext) ? shifted - small_ext : shifted;

   // next multiple's remainder: both terms are below small, so one subtract suffices
   assign sum     = {1'b0, r_ff} + {1'b0, d_ff};
   assign sum_red = (sum >= small_ext) ? sum - small_ext : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         small_ff <= '0;
         r_ff     <= '0;
         d_ff     <= '0;
      end else if (cmd.load) begin
         small_ff <= small_op;
         r_ff     <= '0;
      end else if (cmd.div_step && status.div_last) begin
         d_ff <= part_in[OPERAND_WIDTH-1:0];
         r_ff <= part_in[OPERAND_WIDTH-1:0];
      end else if (cmd.search_step) begin
         r_ff <= sum_red[OPERAND_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         big_ff   <= big;
         shift_ff <= big;
         part_ff  <= '0;
         cnt_ff   <= '0;
         acc_ff   <= (small_op == '0) ? '0 : RESULT_WIDTH'(big);
      end else begin
         if (cmd.div_step) begin
            part_ff  <= part_in;
            shift_ff <= {shift_ff[OPERAND_WIDTH-2:0], 1'b0};
            cnt_ff   <= cnt_ff + 1'b1;
         end
         if (cmd.search_step) begin
            acc_ff <= acc_ff + RESULT_WIDTH'(big_ff);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_ff <= acc_ff;
      end
   end

   assign status.small_zero = (small_ff == '0);
   assign status.div_last   = (cnt_ff == COUNT_WIDTH'(OPERAND_WIDTH - 1));
   assign status.hit        = (r_ff == '0);
   assign status.slot_free  = !out_valid_ff || rsp_ready;

   assign rsp_valid    = out_valid_ff;
   assign rsp_multiple = out_ff;

   remainder_reduced : assert property (@(posedge clock) disable iff (reset)
      (small_ff != '0) |-> (r_ff < small_ff))
      else $error("running remainder not below the smaller operand");

   search_starts_at_big : assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> ((acc_ff == RESULT_WIDTH'(big_ff)) || (acc_ff == '0)))
      else $error("search did not start at the larger operand");

   result_taken_on_hit : assert property (@(posedge clock) disable iff (reset)
      cmd.load_out |=> (out_valid_ff && (out_ff == $past(acc_ff)) && (r_ff == '0)))
      else $error("result register loaded off a hit");

endmodule

// ===== hdl/lcm_by_multiple_search.sv =====
// Sequence: once the operand beat is taken, the remainder unit steps through every bit of
//   the larger operand, then the search walks its multiples up to lcm = larger * k
//   (k <= smaller); a zero operand skips both. A new beat is taken only once the result
//   is in the output register, so a result stall holds it off. Worst case: larger 65535
//   and smaller 65534, so k = 65534. Reset: synchronous, active high;
//   clears the controller, the result valid flag, the smaller operand and the remainders.
`timescale 1ns / 1ps

module lcm_by_multiple_search (
   input  logic      clock,
   input  logic      reset,
   lcm_req_if.sink   req_if,
   lcm_rsp_if.source rsp_if
);
   import lcm_pkg::*;

   lcm_cmd_type    cmd;
   lcm_status_type status;

   lcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   lcm_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .first_operand  (req_if.first_operand),
      .second_operand (req_if.second_operand),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_if.ready),
      .rsp_valid      (rsp_if.valid),
      .rsp_multiple   (rsp_if.multiple)
   );

endmodule

// ===== tb/sv/lcm_multiple_compare.sv =====
// Predicts the least common multiple of each operand beat and compares it with the result beats.
`timescale 1ns / 1ps

module lcm_multiple_compare (
   input  logic clock,
   input  logic reset,
   lcm_req_if   req_mon,
   lcm_rsp_if   rsp_mon,
   output int   failures,
   output int   outstanding
);
   import lcm_pkg::*;

   logic [RESULT_WIDTH-1:0] expected_multiples [$];
   int                      fail_tally = 0;

   // Euclid on the larger and smaller operand, then larger * (smaller / gcd), low bits kept.
   function automatic logic [RESULT_WIDTH-1:0] lcm_of(input logic [OPERAND_WIDTH-1:0] x,
                                                      input logic [OPERAND_WIDTH-1:0] y);
      logic [63:0] larger;
      logic [63:0] smaller;
      logic [63:0] num;
      logic [63:0] den;
      logic [63:0] rem;
      larger  = (x > y) ? 64'(x) : 64'(y);
      smaller = (x > y) ? 64'(y) : 64'(x);
      if (smaller == 0) begin
         return '0;
      end
      num = larger;
      den = smaller;
      while (den != 0) begin
         rem = num % den;
         num = den;
         den = rem;
      end
      return RESULT_WIDTH'(larger * (smaller / num));
   endfunction

   always @(posedge clock) begin
      logic [RESULT_WIDTH-1:0] want;
      if (!reset) begin
         // retire the result beat before queueing a new operand beat
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_multiples.size() == 0) begin
               $error("multiple: no result expected, got %0d", rsp_mon.multiple);
               fail_tally++;
            end else begin
               want = expected_multiples.pop_front();
               if (rsp_mon.multiple !== want) begin
                  $error("multiple: expected %0d, got %0d", want, rsp_mon.multiple);
                  fail_tally++;
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            expected_multiples.push_back(lcm_of(req_mon.first_operand, req_mon.second_operand));
         end
      end
      outstanding <= expected_multiples.size();
   end

   assign failures = fail_tally;

endmodule

// ===== tb/sv/tb_lcm_by_multiple_search.sv =====
// Stimulus and verdict for the least common multiple search block.
`timescale 1ns / 1ps

module tb_lcm_by_multiple_search;
   import lcm_pkg::*;

   localparam int N_DIRECTED    = 18;
   localparam int N_PER_PHASE   = 18;
   localparam int N_PRESSURE    = 8;
   localparam int HOLD_CYCLES   = 600;
   localparam int TAIL_CYCLES   = 100;

   localparam logic [OPERAND_WIDTH-1:0] DIRECTED_FIRST [N_DIRECTED] = '{
      16'd0, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'hFFFF, 16'd1, 16'd12, 16'd18,
      16'd7, 16'h8000, 16'hAAAA, 16'd65521, 16'd255, 16'd2, 16'd40000, 16'hFFFF, 16'hFFFE
   };
   localparam logic [OPERAND_WIDTH-1:0] DIRECTED_SECOND [N_DIRECTED] = '{
      16'd0, 16'hFFFF, 16'd0, 16'd1, 16'hFFFF, 16'd1, 16'hFFFF, 16'd18, 16'd12,
      16'd5, 16'h8000, 16'h5555, 16'd3, 16'hFF00, 16'd0, 16'd40000, 16'hFFFE, 16'hFFFF
   };

   // per phase: sender idle and receiver stall, percent of cycles
   localparam int SEND_IDLE [4] = '{0, 79, 0, 9};
   localparam int RSP_STALL [4] = '{0, 0, 79, 9};

   logic clock;
   logic reset;
   int   failures;
   int   outstanding;
   int   send_idle_pct = 0;
   int   stall_pct     = 0;
   int   hold_ticket   = 0;

   lcm_req_if req_if ();
   lcm_rsp_if rsp_if ();

   lcm_by_multiple_search i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if)
   );

   lcm_multiple_compare i_multiple_compare (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_if),
      .rsp_mon     (rsp_if),
      .failures    (failures),
      .outstanding (outstanding)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one operand beat and hold it until accepted; valid is left high on return.
   task automatic send_pair(input logic [OPERAND_WIDTH-1:0] a, input logic [OPERAND_WIDTH-1:0] b);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid          = 1'b1;
      req_if.first_operand  = a;
      req_if.second_operand = b;
      do @(posedge clock); while (!req_if.ready);
      @(negedge clock);
   endtask

   // Mostly pairs whose search stays short; full-width values reach every operand bit.
   task automatic send_random_pair();
      int unsigned mode;
      int unsigned m;
      int unsigned n;
      int unsigned g;
      logic [OPERAND_WIDTH-1:0] a;
      logic [OPERAND_WIDTH-1:0] b;
      logic [OPERAND_WIDTH-1:0] t;
      mode = $urandom_range(99, 0);
      if (mode < 35) begin
         a = OPERAND_WIDTH'($urandom_range(65535, 0));
         b = OPERAND_WIDTH'($urandom_range(64, 0));
      end else if (mode < 65) begin
         m = $urandom_range(16, 1);
         n = $urandom_range(16, 1);
         g = $urandom_range(65535 / ((m > n) ? m : n), 1);
         a = OPERAND_WIDTH'(g * m);
         b = OPERAND_WIDTH'(g * n);
      end else if (mode < 75) begin
         a = OPERAND_WIDTH'($urandom_range(65535, 0));
         b = a;
      end else if (mode < 85) begin
         a = OPERAND_WIDTH'($urandom_range(65535, 0));
         b = '0;
      end else if (mode < 95) begin
         a = OPERAND_WIDTH'($urandom_range(255, 0));
         b = OPERAND_WIDTH'($urandom_range(255, 0));
      end else begin
         a = OPERAND_WIDTH'($urandom_range(65535, 0));
         b = OPERAND_WIDTH'($urandom_range(2047, 0));
      end
      if ($urandom_range(1, 0)) begin
         t = a;
         a = b;
         b = t;
      end
      send_pair(a, b);
   endtask

   task automatic wait_drain();
      while (outstanding != 0) @(negedge clock);
   endtask

   // Result side: random stalls, plus a long hold-off whenever a new ticket shows up.
   initial begin
      int hold_left;
      int hold_seen;
      hold_left   = 0;
      hold_seen   = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ticket != hold_seen) begin
            hold_seen = hold_ticket;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready = 1'b0;
         end else begin
            rsp_if.ready = ($urandom_range(99, 0) >= stall_pct);
         end
      end
   end

   initial begin
      req_if.valid          = 1'b0;
      req_if.first_operand  = '0;
      req_if.second_operand = '0;
      reset = 1'b1;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int i = 0; i < N_DIRECTED; i++) begin
         send_pair(DIRECTED_FIRST[i], DIRECTED_SECOND[i]);
      end
      req_if.valid = 1'b0;
      wait_drain();

      // hold the result side off while beats keep coming, so the block backs up
      send_idle_pct = 0;
      stall_pct   <= 0;
      hold_ticket <= hold_ticket + 1;
      for (int i = 0; i < N_PRESSURE; i++) begin
         send_random_pair();
      end
      req_if.valid = 1'b0;
      wait_drain();

      for (int p = 0; p < 4; p++) begin
         send_idle_pct = SEND_IDLE[p];
         stall_pct    <= RSP_STALL[p];
         for (int i = 0; i < N_PER_PHASE; i++) begin
            send_random_pair();
         end
         req_if.valid = 1'b0;
         wait_drain();
      end

      repeat (TAIL_CYCLES) @(negedge clock);
      if (failures == 0 && outstanding == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

// ===== files.f =====
hdl/lcm_pkg.sv
hdl/lcm_if.sv
hdl/lcm_ctrl.sv
hdl/lcm_datapath.sv
hdl/lcm_by_multiple_search.sv
tb/sv/lcm_multiple_compare.sv
tb/sv/tb_lcm_by_multiple_search.sv
